[rtl/core/vector3_alu_macros.svh]
// Assertion macros shared by the vector ALU RTL.
`ifndef VECTOR3_ALU_MACROS_SVH
`define VECTOR3_ALU_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define V3A_ASSERT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define V3A_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/v3a_pkg.sv]
// Package with the types, constants and saturation helpers of the vector ALU.
package v3a_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int WORD_BITS = 32;
    localparam int FN_W      = 3;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int DOT_W     = PROD_W + 2;
    localparam int SQ_W      = PROD_W;
    localparam int SQ_STEPS  = SQ_W / 2;
    localparam int ROOT_W    = SQ_W / 2;
    localparam int DIV_Q     = FRAC_BITS + 3;
    localparam int NN_W      = DATA_W + FRAC_BITS + 1;
    localparam int CN_W      = PROD_W + FRAC_BITS + 1;
    localparam int MAG_W     = PROD_W + 2;

    typedef enum logic [FN_W-1:0] {
        FN_SUB   = 3'd0,
        FN_SCALE = 3'd1,
        FN_LEN   = 3'd2,
        FN_NORM  = 3'd3,
        FN_DOT   = 3'd4,
        FN_COS   = 3'd5
    } t_func;

    typedef struct packed {
        logic [FN_W-1:0]          func;
        logic [2:0][DATA_W-1:0]   a;
        logic [2:0][DATA_W-1:0]   b;
        logic [DATA_W-1:0]        s;
    } t_in;

    typedef struct packed {
        logic [FN_W-1:0]          func;
        logic [2:0]               a_neg;
        logic [2:0][DATA_W-1:0]   a_mag;
        logic                     s_neg;
        logic [2:0][DATA_W:0]     diff;
        logic [2:0][PROD_W-1:0]   sq_a;
        logic [2:0][PROD_W-1:0]   sq_b;
        logic [2:0][PROD_W-1:0]   ab_mag;
        logic [2:0]               ab_neg;
        logic [2:0][PROD_W-1:0]   as_mag;
    } t_prod;

    typedef struct packed {
        logic [FN_W-1:0]          func;
        logic [2:0]               a_neg;
        logic [2:0][DATA_W-1:0]   a_mag;
        logic [DOT_W-1:0]         dot_raw;
        logic                     dot_neg;
        logic [PROD_W-1:0]        dot_mag;
        logic [2:0][DATA_W-1:0]   pre_v;
        logic [DATA_W-1:0]        pre_s;
        logic                     pre_sat;
        logic [ROOT_W-1:0]        la;
        logic [ROOT_W-1:0]        lb;
    } t_side;

    typedef struct packed {
        logic [2:0][DATA_W-1:0]   v;
        logic [DATA_W-1:0]        s;
        logic                     err;
        logic                     sat;
    } t_res;

    typedef struct packed {
        logic                     flag;
        logic [DATA_W-1:0]        val;
    } t_sat;

    function automatic t_sat sat_out(input logic neg, input logic [MAG_W-1:0] mag);
        logic [MAG_W-1:0] lim;
        logic [MAG_W-1:0] m;
        logic [MAG_W-1:0] v;
        t_sat             st;
        lim = MAG_W'(1) << (WORD_BITS - 1);
        if (!neg) begin
            lim = lim - MAG_W'(1);
        end
        st.flag = (mag > lim);
        m = st.flag ? lim : mag;
        v = neg ? (~m + MAG_W'(1)) : m;
        st.val = v[DATA_W-1:0];
        return st;
    endfunction

    function automatic logic [MAG_W-1:0] round_frac(input logic [MAG_W-1:0] mag);
        logic [MAG_W:0] t;
        t = {1'b0, mag} + ((MAG_W + 1)'(1) << (FRAC_BITS - 1));
        return MAG_W'(t >> FRAC_BITS);
    endfunction

endpackage

[rtl/core/v3a_sqrt.sv]
// Pipelined digit-by-digit square root with round-to-nearest output.
module v3a_sqrt (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [v3a_pkg::SQ_W-1:0]   i_x,
    output logic [v3a_pkg::ROOT_W-1:0] o_root
);
    import v3a_pkg::*;

    typedef struct packed {
        logic [SQ_W-1:0] x;
        logic [SQ_W-1:0] r;
    } t_sq;

    function automatic t_sq sqrt_step(input t_sq p, input int unsigned k);
        logic [SQ_W-1:0] bitv;
        logic [SQ_W-1:0] trial;
        t_sq             n;
        bitv  = SQ_W'(1) << (SQ_W - 2 - 2 * k);
        trial = p.r + bitv;
        if (p.x >= trial) begin
            n.x = p.x - trial;
            n.r = (p.r >> 1) + bitv;
        end else begin
            n.x = p.x;
            n.r = p.r >> 1;
        end
        return n;
    endfunction

    t_sq r_st [SQ_STEPS];
    t_sq n_st [SQ_STEPS];
    t_sq first;

    always_comb begin
        first.x = i_x;
        first.r = '0;
        n_st[0] = sqrt_step(first, 0);
        for (int k = 1; k < SQ_STEPS; k++) begin
            n_st[k] = sqrt_step(r_st[k-1], k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < SQ_STEPS; k++) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    assign o_root = ROOT_W'(r_st[SQ_STEPS-1].r
                    + SQ_W'(r_st[SQ_STEPS-1].x > r_st[SQ_STEPS-1].r));

endmodule

[rtl/core/v3a_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
module v3a_div #(
    parameter int NUM_W = 49,
    parameter int DEN_W = 32,
    parameter int Q_W   = 19
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [Q_W-1:0]   o_quo
);
    import v3a_pkg::*;

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [Q_W-1:0]   sh;
        logic [DEN_W-1:0] den;
    } t_dv;

    function automatic t_dv div_step(input t_dv p);
        logic [DEN_W:0] t;
        logic           ge;
        t_dv            n;
        t  = {p.rem, p.sh[Q_W-1]};
        ge = (t >= {1'b0, p.den});
        n.rem = ge ? DEN_W'(t - {1'b0, p.den}) : DEN_W'(t);
        n.sh  = {p.sh[Q_W-2:0], ge};
        n.den = p.den;
        return n;
    endfunction

    t_dv r_st [Q_W];
    t_dv n_st [Q_W];
    t_dv first;

    always_comb begin
        first.rem = DEN_W'(i_num >> Q_W);
        first.sh  = i_num[Q_W-1:0];
        first.den = i_den;
        n_st[0] = div_step(first);
        for (int j = 1; j < Q_W; j++) begin
            n_st[j] = div_step(r_st[j-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < Q_W; j++) begin
                r_st[j] <= n_st[j];
            end
        end
    end

    assign o_quo = r_st[Q_W-1].sh;

endmodule

[rtl/core/vector3_alu.sv]
// Top level of the three-component Q16.16 vector ALU pipeline.
//
// Input channel: i_in_valid / o_in_ready with the function code, vectors a
// and b and the scale factor. Output channel: o_out_valid / i_out_ready with
// the vector result, the scalar result and the two flags. One transaction in
// gives exactly one transaction out, in order.
// The Q16.16 pipeline has three front stages for the products and sums,
// 32 square-root stages, three post stages, FRAC_BITS + 3 divider stages and
// the output register. Every operation takes the same path.
// Throughput is one transaction per unstalled cycle; the square-root and
// divider pipelines accept a new operand in every cycle that is not stalled.
// The output side holds up to two finished results. o_in_ready is registered
// and drops only while both are held; the whole pipeline then freezes and
// nothing inside is lost or repeated.
// Reset is synchronous and active low; it empties the pipeline and the output
// register, after which o_in_ready is high.
`include "vector3_alu_macros.svh"
module vector3_alu (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [v3a_pkg::FN_W-1:0]          i_func,
    input  logic signed [v3a_pkg::DATA_W-1:0] i_a_x,
    input  logic signed [v3a_pkg::DATA_W-1:0] i_a_y,
    input  logic signed [v3a_pkg::DATA_W-1:0] i_a_z,
    input  logic signed [v3a_pkg::DATA_W-1:0] i_b_x,
    input  logic signed [v3a_pkg::DATA_W-1:0] i_b_y,
    input  logic signed [v3a_pkg::DATA_W-1:0] i_b_z,
    input  logic signed [v3a_pkg::DATA_W-1:0] i_scale,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [v3a_pkg::DATA_W-1:0] o_r_x,
    output logic signed [v3a_pkg::DATA_W-1:0] o_r_y,
    output logic signed [v3a_pkg::DATA_W-1:0] o_r_z,
    output logic signed [v3a_pkg::DATA_W-1:0] o_r_scalar,
    output logic                              o_zero_length_error,
    output logic                              o_saturated
);
    import v3a_pkg::*;

    logic en;
    logic pop;
    logic push;

    t_in   r_s1, n_s1;
    t_prod r_s2, n_s2;
    t_side r_s3, n_s3;
    logic [SQ_W-1:0] r_s3_sa, n_s3_sa;
    logic [SQ_W-1:0] r_s3_sb, n_s3_sb;
    logic r_s1_v, r_s2_v, r_s3_v;

    t_side r_sq_side [SQ_STEPS];
    logic [SQ_STEPS-1:0] r_sq_v;
    logic [ROOT_W-1:0] root_a;
    logic [ROOT_W-1:0] root_b;

    t_side r_p1, n_p1;
    t_side r_p2, n_p2;
    t_side r_p3;
    logic [PROD_W-1:0] r_p2_lalb, n_p2_lalb;
    logic [2:0][NN_W-1:0] r_p2_nnum, n_p2_nnum;
    logic [PROD_W-1:0] r_p3_lalb;
    logic [2:0][NN_W-1:0] r_p3_nnum;
    logic [CN_W-1:0] r_p3_cnum, n_p3_cnum;
    logic r_p1_v, r_p2_v, r_p3_v;

    t_side r_dv_side [DIV_Q];
    logic [DIV_Q-1:0] r_dv_v;
    logic [2:0][DIV_Q-1:0] norm_q;
    logic [DIV_Q-1:0] cos_q;

    t_res n_res;
    t_res r_q0, r_q1;
    logic r_q0_v, r_q1_v;

    assign en         = !r_q1_v;
    assign o_in_ready = en;

    always_comb begin
        n_s1.func = i_func;
        n_s1.a    = {i_a_z, i_a_y, i_a_x};
        n_s1.b    = {i_b_z, i_b_y, i_b_x};
        n_s1.s    = i_scale;
    end

    always_comb begin
        logic [DATA_W-1:0] am;
        logic [DATA_W-1:0] bm;
        logic [DATA_W-1:0] sm;
        n_s2 = '0;
        n_s2.func  = r_s1.func;
        n_s2.s_neg = r_s1.s[DATA_W-1];
        sm = r_s1.s[DATA_W-1] ? (~r_s1.s + DATA_W'(1)) : r_s1.s;
        for (int i = 0; i < 3; i++) begin
            am = r_s1.a[i][DATA_W-1] ? (~r_s1.a[i] + DATA_W'(1)) : r_s1.a[i];
            bm = r_s1.b[i][DATA_W-1] ? (~r_s1.b[i] + DATA_W'(1)) : r_s1.b[i];
            n_s2.a_neg[i]  = r_s1.a[i][DATA_W-1];
            n_s2.a_mag[i]  = am;
            n_s2.diff[i]   = {r_s1.a[i][DATA_W-1], r_s1.a[i]}
                             - {r_s1.b[i][DATA_W-1], r_s1.b[i]};
            n_s2.sq_a[i]   = PROD_W'(am) * PROD_W'(am);
            n_s2.sq_b[i]   = PROD_W'(bm) * PROD_W'(bm);
            n_s2.ab_mag[i] = PROD_W'(am) * PROD_W'(bm);
            n_s2.ab_neg[i] = r_s1.a[i][DATA_W-1] ^ r_s1.b[i][DATA_W-1];
            n_s2.as_mag[i] = PROD_W'(am) * PROD_W'(sm);
        end
    end

    always_comb begin
        logic [DOT_W-1:0]  dot;
        logic [DATA_W:0]   dmag;
        logic              dneg;
        logic [MAG_W-1:0]  m;
        logic [2:0][DATA_W-1:0] sub_v;
        logic [2:0][DATA_W-1:0] scl_v;
        logic              sub_sat;
        logic              scl_sat;
        t_sat              st;
        n_s3_sa = r_s2.sq_a[0] + r_s2.sq_a[1] + r_s2.sq_a[2];
        n_s3_sb = r_s2.sq_b[0] + r_s2.sq_b[1] + r_s2.sq_b[2];
        dot = '0;
        sub_sat = 1'b0;
        scl_sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            dot = r_s2.ab_neg[i] ? dot - DOT_W'(r_s2.ab_mag[i])
                                 : dot + DOT_W'(r_s2.ab_mag[i]);
            dneg = r_s2.diff[i][DATA_W];
            dmag = dneg ? (~r_s2.diff[i] + (DATA_W + 1)'(1)) : r_s2.diff[i];
            st = sat_out(dneg, MAG_W'(dmag));
            sub_v[i] = st.val;
            sub_sat  = sub_sat | st.flag;
            m  = round_frac(MAG_W'(r_s2.as_mag[i]));
            st = sat_out((r_s2.a_neg[i] ^ r_s2.s_neg) && (m != '0), m);
            scl_v[i] = st.val;
            scl_sat  = scl_sat | st.flag;
        end
        n_s3 = '0;
        n_s3.func    = r_s2.func;
        n_s3.a_neg   = r_s2.a_neg;
        n_s3.a_mag   = r_s2.a_mag;
        n_s3.dot_raw = dot;
        if (r_s2.func == FN_SUB) begin
            n_s3.pre_v   = sub_v;
            n_s3.pre_sat = sub_sat;
        end else if (r_s2.func == FN_SCALE) begin
            n_s3.pre_v   = scl_v;
            n_s3.pre_sat = scl_sat;
        end
    end

    v3a_sqrt u_sqrt_a (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_x    (r_s3_sa),
        .o_root (root_a)
    );

    v3a_sqrt u_sqrt_b (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_x    (r_s3_sb),
        .o_root (root_b)
    );

    always_comb begin
        logic [DOT_W-1:0] dabs;
        n_p1 = r_sq_side[SQ_STEPS-1];
        n_p1.la = root_a;
        n_p1.lb = root_b;
        n_p1.dot_neg = n_p1.dot_raw[DOT_W-1];
        dabs = n_p1.dot_neg ? (~n_p1.dot_raw + DOT_W'(1)) : n_p1.dot_raw;
        n_p1.dot_mag = dabs[PROD_W-1:0];
    end

    always_comb begin
        logic [MAG_W-1:0] m;
        t_sat             st;
        n_p2 = r_p1;
        n_p2_lalb = PROD_W'(r_p1.la) * PROD_W'(r_p1.lb);
        for (int i = 0; i < 3; i++) begin
            n_p2_nnum[i] = (NN_W'(r_p1.a_mag[i]) << FRAC_BITS) + NN_W'(r_p1.la >> 1);
        end
        m  = round_frac(MAG_W'(r_p1.dot_mag));
        st = sat_out(r_p1.dot_neg && (m != '0), m);
        if (r_p1.func == FN_DOT) begin
            n_p2.pre_s   = st.val;
            n_p2.pre_sat = st.flag;
        end
    end

    assign n_p3_cnum = (CN_W'(r_p2.dot_mag) << FRAC_BITS) + CN_W'(r_p2_lalb >> 1);

    for (genvar g = 0; g < 3; g++) begin : g_norm
        v3a_div #(
            .NUM_W (NN_W),
            .DEN_W (ROOT_W),
            .Q_W   (DIV_Q)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (r_p3_nnum[g]),
            .i_den (r_p3.la),
            .o_quo (norm_q[g])
        );
    end

    v3a_div #(
        .NUM_W (CN_W),
        .DEN_W (PROD_W),
        .Q_W   (DIV_Q)
    ) u_div_cos (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_p3_cnum),
        .i_den (r_p3_lalb),
        .o_quo (cos_q)
    );

    always_comb begin
        t_side sd;
        t_sat  st;
        sd = r_dv_side[DIV_Q-1];
        st = '0;
        n_res = '0;
        case (t_func'(sd.func))
            FN_SUB, FN_SCALE: begin
                n_res.v   = sd.pre_v;
                n_res.sat = sd.pre_sat;
            end
            FN_DOT: begin
                n_res.s   = sd.pre_s;
                n_res.sat = sd.pre_sat;
            end
            FN_LEN: begin
                st = sat_out(1'b0, MAG_W'(sd.la));
                n_res.s   = st.val;
                n_res.sat = st.flag;
            end
            FN_NORM: begin
                if (sd.la == '0) begin
                    n_res.err = 1'b1;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        st = sat_out(sd.a_neg[i], MAG_W'(norm_q[i]));
                        n_res.v[i] = st.val;
                        n_res.sat  = n_res.sat | st.flag;
                    end
                end
            end
            FN_COS: begin
                if (sd.la == '0 || sd.lb == '0) begin
                    n_res.err = 1'b1;
                end else begin
                    st = sat_out(sd.dot_neg && (cos_q != '0), MAG_W'(cos_q));
                    n_res.s   = st.val;
                    n_res.sat = st.flag;
                end
            end
            default: begin
                n_res = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_sq_v <= '0;
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
            r_p3_v <= 1'b0;
            r_dv_v <= '0;
        end else if (en) begin
            r_s1_v <= i_in_valid;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_sq_v <= {r_sq_v[SQ_STEPS-2:0], r_s3_v};
            r_p1_v <= r_sq_v[SQ_STEPS-1];
            r_p2_v <= r_p1_v;
            r_p3_v <= r_p2_v;
            r_dv_v <= {r_dv_v[DIV_Q-2:0], r_p3_v};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1    <= n_s1;
            r_s2    <= n_s2;
            r_s3    <= n_s3;
            r_s3_sa <= n_s3_sa;
            r_s3_sb <= n_s3_sb;
            r_sq_side[0] <= r_s3;
            for (int k = 1; k < SQ_STEPS; k++) begin
                r_sq_side[k] <= r_sq_side[k-1];
            end
            r_p1      <= n_p1;
            r_p2      <= n_p2;
            r_p2_lalb <= n_p2_lalb;
            r_p2_nnum <= n_p2_nnum;
            r_p3      <= r_p2;
            r_p3_lalb <= r_p2_lalb;
            r_p3_nnum <= r_p2_nnum;
            r_p3_cnum <= n_p3_cnum;
            r_dv_side[0] <= r_p3;
            for (int j = 1; j < DIV_Q; j++) begin
                r_dv_side[j] <= r_dv_side[j-1];
            end
        end
    end

    assign pop  = r_q0_v && i_out_ready;
    assign push = en && r_dv_v[DIV_Q-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q0_v <= 1'b0;
            r_q1_v <= 1'b0;
        end else if (r_q1_v) begin
            if (pop) begin
                r_q1_v <= 1'b0;
            end
        end else if (!r_q0_v || pop) begin
            r_q0_v <= push;
        end else if (push) begin
            r_q1_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_q1_v) begin
            if (pop) begin
                r_q0 <= r_q1;
            end
        end else if (!r_q0_v || pop) begin
            r_q0 <= n_res;
        end else if (push) begin
            r_q1 <= n_res;
        end
    end

    assign o_out_valid         = r_q0_v;
    assign o_r_x               = r_q0.v[0];
    assign o_r_y               = r_q0.v[1];
    assign o_r_z               = r_q0.v[2];
    assign o_r_scalar          = r_q0.s;
    assign o_zero_length_error = r_q0.err;
    assign o_saturated         = r_q0.sat;

    `V3A_ASSERT(a_err_zero, i_clk, i_rst_n, o_out_valid && o_zero_length_error, !o_saturated && o_r_scalar == '0 && o_r_x == '0 && o_r_y == '0 && o_r_z == '0, "zero-length error with a nonzero result")
    `V3A_ASSERT(a_queue_order, i_clk, i_rst_n, r_q1_v, r_q0_v, "second result held without a first")
    `V3A_ASSERT_NEXT(a_end_hold, i_clk, i_rst_n, r_dv_v[DIV_Q-1] && !o_in_ready, r_dv_v[DIV_Q-1], "finished transaction dropped during a stall")

endmodule

[tb/vector3_alu_test.sv]
// Self-checking testbench for the three-component fixed-point vector ALU.
module vector3_alu_test;
    timeunit 1ns;
    timeprecision 1ps;
    import v3a_pkg::*;

    typedef struct {
        logic [FN_W-1:0] fn;
        int ax, ay, az, bx, by, bz, sc;
    } t_vec_op;

    typedef struct {
        int rx, ry, rz, rs;
        bit err, sat;
    } t_vec_res;

    class vector_scoreboard;
        t_vec_res pending_results[$];
        int       mismatches;

        function new();
            mismatches = 0;
        endfunction

        static function int clamp_word(bit neg, bit [65:0] mag, ref bit flag);
            bit [65:0] lim;
            lim = neg ? 66'h80000000 : 66'h7fffffff;
            if (mag > lim) begin
                mag = lim;
                flag = 1'b1;
            end
            return neg ? -int'(mag[31:0]) : int'(mag[31:0]);
        endfunction

        static function bit [65:0] abs_word(int v);
            longint l;
            l = v;
            return (l < 0) ? 66'(-l) : 66'(l);
        endfunction

        static function bit [65:0] rounded_root(bit [65:0] x);
            bit [65:0] r;
            bit [65:0] t;
            r = 0;
            for (int i = 32; i >= 0; i--) begin
                t = r | (66'd1 << i);
                if (t * t <= x) begin
                    r = t;
                end
            end
            if (x - r * r > r) begin
                r = r + 1;
            end
            return r;
        endfunction

        static function bit [65:0] length_of(int x, int y, int z);
            bit [65:0] a;
            bit [65:0] b;
            bit [65:0] c;
            a = abs_word(x);
            b = abs_word(y);
            c = abs_word(z);
            return rounded_root(a * a + b * b + c * c);
        endfunction

        static function t_vec_res compute(t_vec_op op);
            t_vec_res          r;
            int                av[3];
            int                bv[3];
            longint            d;
            bit [65:0]         m;
            bit [65:0]         la;
            bit [65:0]         lb;
            logic signed [67:0] acc;
            bit [127:0]        num;
            bit [127:0]        q;
            bit [127:0]        den;
            r = '{0, 0, 0, 0, 1'b0, 1'b0};
            av = '{op.ax, op.ay, op.az};
            bv = '{op.bx, op.by, op.bz};
            acc = 0;
            for (int i = 0; i < 3; i++) begin
                acc = acc + 68'(longint'(av[i]) * longint'(bv[i]));
            end
            case (op.fn)
                FN_SUB: begin
                    for (int i = 0; i < 3; i++) begin
                        d = longint'(av[i]) - longint'(bv[i]);
                        av[i] = clamp_word(d < 0, (d < 0) ? 66'(-d) : 66'(d), r.sat);
                    end
                    r.rx = av[0]; r.ry = av[1]; r.rz = av[2];
                end
                FN_SCALE: begin
                    for (int i = 0; i < 3; i++) begin
                        m = (abs_word(av[i]) * abs_word(op.sc) + 66'h8000) >> FRAC_BITS;
                        av[i] = clamp_word(((av[i] < 0) != (op.sc < 0)) && m != 0, m, r.sat);
                    end
                    r.rx = av[0]; r.ry = av[1]; r.rz = av[2];
                end
                FN_LEN: begin
                    r.rs = clamp_word(1'b0, length_of(op.ax, op.ay, op.az), r.sat);
                end
                FN_NORM: begin
                    la = length_of(op.ax, op.ay, op.az);
                    if (la == 0) begin
                        r.err = 1'b1;
                    end else begin
                        for (int i = 0; i < 3; i++) begin
                            m = ((abs_word(av[i]) << FRAC_BITS) + (la >> 1)) / la;
                            av[i] = clamp_word(av[i] < 0, m, r.sat);
                        end
                        r.rx = av[0]; r.ry = av[1]; r.rz = av[2];
                    end
                end
                FN_DOT: begin
                    m = (acc < 0) ? 66'(-acc) : 66'(acc);
                    m = (m + 66'h8000) >> FRAC_BITS;
                    r.rs = clamp_word(acc < 0 && m != 0, m, r.sat);
                end
                FN_COS: begin
                    la = length_of(op.ax, op.ay, op.az);
                    lb = length_of(op.bx, op.by, op.bz);
                    if (la == 0 || lb == 0) begin
                        r.err = 1'b1;
                    end else begin
                        m = (acc < 0) ? 66'(-acc) : 66'(acc);
                        den = 128'(la * lb);
                        num = (128'(m) << FRAC_BITS) + (den >> 1);
                        q = num / den;
                        if (q > (128'd1 << 63)) begin
                            q = 128'd1 << 63;
                        end
                        r.rs = clamp_word(acc < 0 && q != 0, 66'(q), r.sat);
                    end
                end
                default: begin
                end
            endcase
            return r;
        endfunction

        function void note_operation(t_vec_op op);
            pending_results.push_back(compute(op));
        endfunction

        function void check_result(t_vec_res got);
            t_vec_res want;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR: unexpected result transaction at %0t", $realtime);
                end
                return;
            end
            want = pending_results.pop_front();
            if (want != got) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR: expected %h %h %h %h err=%0b sat=%0b", want.rx, want.ry,
                             want.rz, want.rs, want.err, want.sat);
                    $display("       actual   %h %h %h %h err=%0b sat=%0b", got.rx, got.ry,
                             got.rz, got.rs, got.err, got.sat);
                end
            end
        endfunction
    endclass

    logic            i_clk;
    logic            i_rst_n;
    logic            i_in_valid;
    logic            o_in_ready;
    logic [FN_W-1:0] i_func;
    logic signed [DATA_W-1:0] i_a_x, i_a_y, i_a_z, i_b_x, i_b_y, i_b_z, i_scale;
    logic            o_out_valid;
    logic            i_out_ready;
    logic signed [DATA_W-1:0] o_r_x, o_r_y, o_r_z, o_r_scalar;
    logic            o_zero_length_error;
    logic            o_saturated;

    vector3_alu u_top (.*);

    vector_scoreboard board = new();
    int  send_idle_pct;
    int  recv_stall_pct;
    int  hold_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("vector3_alu regression: fail");
        $finish;
    end

    initial begin
        t_vec_res got;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_out_ready = 1'b0;
            end else begin
                i_out_ready = ($urandom_range(99) >= recv_stall_pct);
            end
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                got = '{o_r_x, o_r_y, o_r_z, o_r_scalar, o_zero_length_error, o_saturated};
                board.check_result(got);
            end
        end
    end

    function automatic int random_word();
        case ($urandom_range(6))
            0: return $urandom();
            1: return $signed($urandom_range(8 << 16)) - (4 << 16);
            2: return ($urandom_range(1)) ? 32'h7fffffff : 32'h80000000;
            3: return 0;
            4: return $signed($urandom_range(1 << 22)) - (1 << 21);
            default: return $signed($urandom_range(1 << 26)) - (1 << 25);
        endcase
    endfunction

    function automatic t_vec_op random_op();
        t_vec_op op;
        int      f;
        f = $urandom_range(15);
        op.fn = (f >= 14) ? FN_W'(f - 8) : FN_W'(f % 6);
        op.ax = random_word(); op.ay = random_word(); op.az = random_word();
        op.bx = random_word(); op.by = random_word(); op.bz = random_word();
        op.sc = random_word();
        if ($urandom_range(9) == 0) begin
            op.ax = 0; op.ay = 0; op.az = 0;
        end
        if ($urandom_range(9) == 0) begin
            op.bx = 0; op.by = 0; op.bz = 0;
        end
        return op;
    endfunction

    task automatic send_operation(t_vec_op op);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_func = op.fn;
        i_a_x = op.ax; i_a_y = op.ay; i_a_z = op.az;
        i_b_x = op.bx; i_b_y = op.by; i_b_z = op.bz;
        i_scale = op.sc;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        board.note_operation(op);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (board.pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        t_vec_op op;
        int      mins[] = '{32'h80000000, 32'h7fffffff, 0, 1, -1, 1 << 16};
        hold_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_func = '0;
        {i_a_x, i_a_y, i_a_z, i_b_x, i_b_y, i_b_z, i_scale} = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int f = 0; f < 8; f++) begin
            for (int k = 0; k < 3; k++) begin
                op.fn = FN_W'(f);
                op.ax = (k == 2) ? 0 : mins[k];
                op.ay = (k == 2) ? 0 : mins[k];
                op.az = (k == 2) ? 0 : mins[(k + 1) % 2];
                op.bx = mins[(k + 1) % 2]; op.by = mins[k]; op.bz = mins[k];
                op.sc = mins[k];
                send_operation(op);
            end
        end
        drain_results();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1) ? 68 : (ph == 3) ? 31 : 0;
            recv_stall_pct = (ph == 2) ? 68 : (ph == 3) ? 31 : 0;
            if (ph == 0) begin
                hold_cycles = 300;
            end
            for (int n = 0; n < 450; n++) begin
                send_operation(random_op());
            end
            drain_results();
        end

        recv_stall_pct = 0;
        repeat (80) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending_results.size() == 0) begin
            $display("vector3_alu regression: pass");
        end else begin
            $display("vector3_alu regression: fail");
        end
        $finish;
    end
endmodule
